// ===== hdl/lsc_pkg.sv =====
`default_nettype none
package lsc_pkg;

    localparam int CW       = 12;          // coordinate width
    localparam int NW       = CW + 1;      // ratio numerator / difference width
    localparam int PW       = 2 * NW;      // product width
    localparam int SW       = PW + 1;      // sum of two products
    localparam int MW       = PW;          // magnitude of a sum
    localparam int DIV_BITS = CW;          // quotient bits per coordinate
    localparam int LANES    = 4;
    localparam int FRONT    = 5;           // stages before the divider
    localparam int NSTAGE   = FRONT + DIV_BITS;

    // Configuration register indexes.
    localparam logic [1:0] REG_WIN_LEFT   = 2'd0;
    localparam logic [1:0] REG_WIN_BOTTOM = 2'd1;
    localparam logic [1:0] REG_WIN_RIGHT  = 2'd2;
    localparam logic [1:0] REG_WIN_TOP    = 2'd3;

    typedef struct packed {
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
    } seg_in_t;

    typedef struct packed {
        logic                 visible;
        logic signed [CW-1:0] clip_start_x;
        logic signed [CW-1:0] clip_start_y;
        logic signed [CW-1:0] clip_end_x;
        logic signed [CW-1:0] clip_end_y;
    } seg_out_t;

    // Exact ratio n/d with d > 0.
    typedef struct packed {
        logic signed [NW-1:0] n;
        logic [CW-1:0]        d;
    } ratio_t;

    typedef struct packed {
        logic [MW-1:0]       rem;
        logic [DIV_BITS-1:0] quo;
        logic [CW-1:0]       den;
        logic                neg;
    } div_lane_t;

    // One restoring division step for quotient bit b.
    function automatic div_lane_t div_step(div_lane_t x, int b);
        div_lane_t     y;
        logic [MW-1:0] trial;
        y     = x;
        trial = MW'(x.den) << b;
        if (x.rem >= trial) begin
            y.rem    = x.rem - trial;
            y.quo[b] = 1'b1;
        end
        return y;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/line_segment_clipper_top.sv =====
`default_nettype none
// Channel | Direction | Ports
// input   | in        | s_valid, s_ready, s_data (seg_in_t)
// result  | out       | m_valid, m_ready, m_data (seg_out_t)
// config  | in        | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// One segment per cycle unless the output stalls; five setup stages and a
// twelve-stage restoring divider, one quotient bit per stage, per coordinate.
// Reset (aresetn low, synchronous) clears the window and all valid bits.
// Each stage moves when it is empty or the next one moves, so bubbles close
// up under a stall and nothing is lost or repeated.
module line_segment_clipper_top
    import lsc_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire seg_in_t       s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output seg_out_t           m_data,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [CW-1:0] cfg_data
);

    // Stage payload types.
    typedef struct packed {
        logic signed [NW-1:0] sx, sy, dx, dy;
        ratio_t xen, xlv, yen, ylv;
        logic xhas, yhas, ok;
    } st_a_t;

    typedef struct packed {
        logic signed [NW-1:0] sx, sy, dx, dy;
        ratio_t t1, t2, yen, ylv;
        logic yhas, ok;
    } st_b_t;

    typedef struct packed {
        logic signed [NW-1:0] sx, sy, dx, dy;
        ratio_t t1, t2;
        logic ok;
    } st_c_t;

    typedef struct packed {
        logic signed [PW-1:0] va, vb;
        logic signed [PW-1:0] m0, n0, m1, n1, m2, n2, m3, n3;
        logic [CW-1:0] d1, d2;
        logic ok;
    } st_d_t;

    logic signed [CW-1:0] win_left_reg, win_bottom_reg, win_right_reg, win_top_reg;
    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] en;
    st_a_t a_reg, a_next;
    st_b_t b_reg, b_next;
    st_c_t c_reg, c_next;
    st_d_t d_reg, d_next;
    div_lane_t e_reg [LANES];
    div_lane_t e_next [LANES];
    logic e_vis_reg, e_vis_next;
    div_lane_t div_reg [DIV_BITS][LANES];
    div_lane_t div_next [DIV_BITS][LANES];
    logic [DIV_BITS-1:0] div_vis_reg;
    logic [CW-1:0] coord [LANES];

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_left_reg   <= '0;
            win_bottom_reg <= '0;
            win_right_reg  <= '0;
            win_top_reg    <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_WIN_LEFT:   win_left_reg   <= cfg_data;
                REG_WIN_BOTTOM: win_bottom_reg <= cfg_data;
                REG_WIN_RIGHT:  win_right_reg  <= cfg_data;
                REG_WIN_TOP:    win_top_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Stage enables: a stage loads when it is empty or its content moves on.
    always_comb begin
        en[NSTAGE-1] = !v_reg[NSTAGE-1] || m_ready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign s_ready = en[0];
    assign m_valid = v_reg[NSTAGE-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int i = 1; i < NSTAGE; i++) begin
                if (en[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Stage A: deltas, edge distances and the entering/leaving candidates.
    always_comb begin
        logic signed [NW-1:0] sx, sy, ex, ey, q0, q1, q2, q3;
        sx = NW'(s_data.start_x);
        sy = NW'(s_data.start_y);
        ex = NW'(s_data.end_x);
        ey = NW'(s_data.end_y);
        q0 = sx - NW'(win_left_reg);
        q1 = NW'(win_right_reg) - sx;
        q2 = sy - NW'(win_bottom_reg);
        q3 = NW'(win_top_reg) - sy;
        a_next.sx = sx;
        a_next.sy = sy;
        a_next.dx = ex - sx;
        a_next.dy = ey - sy;
        a_next.xhas = (a_next.dx != '0);
        a_next.yhas = (a_next.dy != '0);
        if (a_next.dx > 0) begin
            a_next.xen.n = -q0;
            a_next.xlv.n = q1;
            a_next.xen.d = a_next.dx[CW-1:0];
        end else begin
            a_next.xen.n = -q1;
            a_next.xlv.n = q0;
            a_next.xen.d = CW'(-a_next.dx);
        end
        a_next.xlv.d = a_next.xen.d;
        if (a_next.dy > 0) begin
            a_next.yen.n = -q2;
            a_next.ylv.n = q3;
            a_next.yen.d = a_next.dy[CW-1:0];
        end else begin
            a_next.yen.n = -q3;
            a_next.ylv.n = q2;
            a_next.yen.d = CW'(-a_next.dy);
        end
        a_next.ylv.d = a_next.yen.d;
        // A segment parallel to an edge and outside it is rejected.
        a_next.ok = !((!a_next.xhas && (q0 < 0 || q1 < 0)) ||
                      (!a_next.yhas && (q2 < 0 || q3 < 0)));
    end

    // Stage B: fold the x candidates into t1 = 0 and t2 = 1.
    always_comb begin
        b_next.sx   = a_reg.sx;
        b_next.sy   = a_reg.sy;
        b_next.dx   = a_reg.dx;
        b_next.dy   = a_reg.dy;
        b_next.yen  = a_reg.yen;
        b_next.ylv  = a_reg.ylv;
        b_next.yhas = a_reg.yhas;
        b_next.ok   = a_reg.ok;
        b_next.t1.n = '0;
        b_next.t1.d = CW'(1);
        b_next.t2.n = NW'(1);
        b_next.t2.d = CW'(1);
        if (a_reg.xhas && a_reg.xen.n > 0) begin
            b_next.t1 = a_reg.xen;
        end
        if (a_reg.xhas && a_reg.xlv.n < $signed({1'b0, a_reg.xlv.d})) begin
            b_next.t2 = a_reg.xlv;
        end
    end

    // Stage C: fold the y candidates in by cross-multiplication.
    always_comb begin
        logic signed [PW-1:0] p_yen, p_t1, p_ylv, p_t2;
        p_yen = b_reg.yen.n * $signed({1'b0, b_reg.t1.d});
        p_t1  = b_reg.t1.n  * $signed({1'b0, b_reg.yen.d});
        p_ylv = b_reg.ylv.n * $signed({1'b0, b_reg.t2.d});
        p_t2  = b_reg.t2.n  * $signed({1'b0, b_reg.ylv.d});
        c_next.sx = b_reg.sx;
        c_next.sy = b_reg.sy;
        c_next.dx = b_reg.dx;
        c_next.dy = b_reg.dy;
        c_next.ok = b_reg.ok;
        c_next.t1 = (b_reg.yhas && p_yen > p_t1) ? b_reg.yen : b_reg.t1;
        c_next.t2 = (b_reg.yhas && p_ylv < p_t2) ? b_reg.ylv : b_reg.t2;
    end

    // Stage D: visibility cross products and coordinate numerator products.
    always_comb begin
        logic signed [NW-1:0] d1s, d2s;
        d1s = $signed({1'b0, c_reg.t1.d});
        d2s = $signed({1'b0, c_reg.t2.d});
        d_next.va = c_reg.t1.n * d2s;
        d_next.vb = c_reg.t2.n * d1s;
        d_next.m0 = c_reg.sx * d1s;
        d_next.n0 = c_reg.t1.n * c_reg.dx;
        d_next.m1 = c_reg.sy * d1s;
        d_next.n1 = c_reg.t1.n * c_reg.dy;
        d_next.m2 = c_reg.sx * d2s;
        d_next.n2 = c_reg.t2.n * c_reg.dx;
        d_next.m3 = c_reg.sy * d2s;
        d_next.n3 = c_reg.t2.n * c_reg.dy;
        d_next.d1 = c_reg.t1.d;
        d_next.d2 = c_reg.t2.d;
        d_next.ok = c_reg.ok;
    end

    // Stage E: visible flag, numerator sums split into sign and magnitude.
    always_comb begin
        logic signed [SW-1:0] sum [LANES];
        sum[0] = SW'(d_reg.m0) + SW'(d_reg.n0);
        sum[1] = SW'(d_reg.m1) + SW'(d_reg.n1);
        sum[2] = SW'(d_reg.m2) + SW'(d_reg.n2);
        sum[3] = SW'(d_reg.m3) + SW'(d_reg.n3);
        e_vis_next = d_reg.ok && (d_reg.va < d_reg.vb);
        for (int l = 0; l < LANES; l++) begin
            e_next[l].neg = sum[l][SW-1];
            e_next[l].rem = sum[l][SW-1] ? MW'(-sum[l]) : sum[l][MW-1:0];
            e_next[l].quo = '0;
            e_next[l].den = (l < 2) ? d_reg.d1 : d_reg.d2;
        end
    end

    // Divider: one quotient bit per stage, most significant first.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            div_next[0][l] = div_step(e_reg[l], DIV_BITS - 1);
            for (int k = 1; k < DIV_BITS; k++) begin
                div_next[k][l] = div_step(div_reg[k-1][l], DIV_BITS - 1 - k);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (en[0]) a_reg <= a_next;
        if (en[1]) b_reg <= b_next;
        if (en[2]) c_reg <= c_next;
        if (en[3]) d_reg <= d_next;
        if (en[4]) begin
            e_reg     <= e_next;
            e_vis_reg <= e_vis_next;
        end
        if (en[FRONT]) begin
            div_reg[0]     <= div_next[0];
            div_vis_reg[0] <= e_vis_reg;
        end
        for (int k = 1; k < DIV_BITS; k++) begin
            if (en[FRONT+k]) begin
                div_reg[k]     <= div_next[k];
                div_vis_reg[k] <= div_vis_reg[k-1];
            end
        end
    end

    // Result: restore the sign of each quotient; zero when not visible.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            coord[l] = div_reg[DIV_BITS-1][l].neg ? CW'(-div_reg[DIV_BITS-1][l].quo)
                                                  : div_reg[DIV_BITS-1][l].quo;
            if (!div_vis_reg[DIV_BITS-1]) begin
                coord[l] = '0;
            end
        end
        m_data.visible      = div_vis_reg[DIV_BITS-1];
        m_data.clip_start_x = coord[0];
        m_data.clip_start_y = coord[1];
        m_data.clip_end_x   = coord[2];
        m_data.clip_end_y   = coord[3];
    end

    // An empty output stage always lets the pipeline take a transaction.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready) else $error("s_ready low with empty output stage");

    // An accepted transaction occupies the first stage next cycle.
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v_reg[0]) else $error("accepted item lost at entry");

    // A rejected segment carries all-zero coordinates.
    a_zero_hidden: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.visible |-> (m_data.clip_start_x == '0 &&
        m_data.clip_start_y == '0 && m_data.clip_end_x == '0 &&
        m_data.clip_end_y == '0)) else $error("hidden result with nonzero coords");

    // A visible clipped point lies within range, so the start-x quotient does not exceed 2^(CW-1).
    a_quo_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.visible |->
        div_reg[DIV_BITS-1][0].quo <= DIV_BITS'(1 << (CW - 1)))
        else $error("quotient out of range");

endmodule
`default_nettype wire
